FILE: sv/murmur3_x64_128_hash_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash unit
// Clocked on clk_i, with checking held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MURMUR3_X64_128_HASH_UNIT_MACROS_SVH
`define MURMUR3_X64_128_HASH_UNIT_MACROS_SVH

// Consequent checked at the same edge as the antecedent
`define MMH3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked at the edge after the antecedent
`define MMH3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mmh3_pkg.sv
// ----------------------------------------------------------------------------
// mmh3_pkg
// Types and constants shared by the 128-bit x64 MurmurHash3 unit.
// ----------------------------------------------------------------------------
package mmh3_pkg;

  localparam logic [63:0] MIX_C1 = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2 = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] MIX_N1 = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] MIX_N2 = 64'h0000_0000_3849_5ab5;
  localparam logic [63:0] FMIX_F1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_F2 = 64'hc4ce_b9fe_1a85_ec53;

  localparam logic [4:0] BLOCK_BYTES = 5'd16;

  localparam int MMH3_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  byte_count;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_first;
    logic [63:0] hash_second;
  } out_item_t;

  // Classified block as handed from the front end to the core
  typedef struct packed {
    logic [63:0] word_lo;
    logic [63:0] word_hi;
    logic [4:0]  byte_count;
    logic        is_last;
    logic        full_block;
    logic        mix_lo;
    logic        mix_hi;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic key_start;
  } core_stat_t;

endpackage

FILE: sv/murmur3_x64_128_hash_unit.sv
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash_unit
// 128-bit x64 MurmurHash3 of a key streamed in 16-byte blocks.
// ----------------------------------------------------------------------------
// Input channel: one transaction per 16-byte block, low and high words
// little-endian. Mark the final block with is_last and give its valid byte
// count (0 to 16, larger values count as 16); earlier blocks count as 16.
// Output channel: one transaction per key carrying both 64-bit halves.
// Seed: write cfg_wdata_i with cfg_we_i while the unit is idle; it is
// loaded into both lanes when the next key starts.
// Schedule: a queue of QueueDepth blocks decouples input from the core. The
// core's work on a block is set by four dependent 64-bit multiplies
// interleaved on one two-stage multiplier; a queued block that follows a
// body block of the same key starts in that block's last step. The last
// block adds finalisation and output steps before out_valid_o rises.
// Stall: a result waits in the output register; the core holds at the end
// of the next key until it is taken, while the queue accepts until full.
// Reset: seed 0, queue empty, output invalid, next block starts a key.
// ----------------------------------------------------------------------------
`include "murmur3_x64_128_hash_unit_macros.svh"

module murmur3_x64_128_hash_unit
  import mmh3_pkg::*;
#(
  parameter int QueueDepth = MMH3_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  cmd_t       push_cmd;
  cmd_t       head_cmd;
  logic       q_push;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  core_stat_t core_stat;

  mmh3_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .cmd_o      (push_cmd)
  );

  mmh3_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (head_cmd)
  );

  mmh3_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_i       (head_cmd),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .stat_o       (core_stat)
  );

  `MMH3_ASSERT_NEXT(a_push_queued, in_valid_i && in_ready_o, q_valid, "transaction not queued")
  `MMH3_ASSERT_SAME(a_pop_needs_entry, q_pop, q_valid, "core popped an empty queue")
  `MMH3_ASSERT_SAME(a_result_ends_key, $rose(out_valid_o), core_stat.key_start, "result mid-key")

endmodule

FILE: sv/mmh3_front.sv
// ----------------------------------------------------------------------------
// mmh3_front
// Accepts input transactions and classifies each block as full or tail,
// masking unused bytes, before it enters the queue.
// ----------------------------------------------------------------------------
module mmh3_front
  import mmh3_pkg::*;
(
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  logic [4:0] cnt_sat;
  logic [4:0] cnt_eff;
  logic [3:0] lo_bytes;
  logic [3:0] hi_bytes;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // Saturate oversize counts; a block that is not last always counts in full
  assign cnt_sat  = (in_data_i.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : in_data_i.byte_count;
  assign cnt_eff  = in_data_i.is_last ? cnt_sat : BLOCK_BYTES;
  assign lo_bytes = (cnt_eff >= 5'd8) ? 4'd8 : cnt_eff[3:0];
  assign hi_bytes = 4'(cnt_eff - 5'd8);

  always_comb begin
    cmd_o.word_lo    = in_data_i.data_low & byte_mask(lo_bytes);
    cmd_o.word_hi    = in_data_i.data_high & byte_mask(hi_bytes);
    cmd_o.byte_count = cnt_eff;
    cmd_o.is_last    = in_data_i.is_last;
    cmd_o.full_block = (cnt_eff == BLOCK_BYTES);
    cmd_o.mix_lo     = (cnt_eff != 5'd0);
    cmd_o.mix_hi     = (cnt_eff > 5'd8);
  end

endmodule

FILE: sv/mmh3_queue.sv
// ----------------------------------------------------------------------------
// mmh3_queue
// Short FIFO of classified blocks between the front end and the core.
// ----------------------------------------------------------------------------
module mmh3_queue
  import mmh3_pkg::*;
#(
  parameter int Depth = MMH3_QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t data_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/mmh3_mul.sv
// ----------------------------------------------------------------------------
// mmh3_mul
// Two-stage pipelined 64x64 multiplier keeping the low 64 bits of the
// product. A new operand pair may enter every cycle; the partial products
// and then the product are registered.
// ----------------------------------------------------------------------------
module mmh3_mul (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] pp_lo_d, pp_lo_q;
  logic [31:0] pp_x_d, pp_x_q;
  logic [63:0] prod_d, prod_q;

  // Cross products only reach the upper half, so their low 32 bits suffice
  assign pp_lo_d = a_i[31:0] * b_i[31:0];
  assign pp_x_d  = a_i[31:0] * b_i[63:32] + a_i[63:32] * b_i[31:0];
  assign prod_d  = pp_lo_q + {pp_x_q, 32'h0};
  assign prod_o  = prod_q;

  always_ff @(posedge clk_i) begin
    pp_lo_q <= pp_lo_d;
    pp_x_q  <= pp_x_d;
    prod_q  <= prod_d;
  end

endmodule

FILE: sv/mmh3_core.sv
// ----------------------------------------------------------------------------
// mmh3_core
// Sequencer that mixes queued blocks into the two hash lanes, finalises the
// key on its last block and holds the result for the output channel.
// ----------------------------------------------------------------------------
module mmh3_core
  import mmh3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  cmd_t        head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  output core_stat_t  stat_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BLOCK = 4'b0010,
    ST_FINAL = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // Block steps (step zero is the cycle that pops the block)
  localparam logic [3:0] BLK_HI     = 4'd1;
  localparam logic [3:0] BLK_ROT_LO = 4'd2;
  localparam logic [3:0] BLK_ROT_HI = 4'd3;
  localparam logic [3:0] BLK_LANE1  = 4'd4;
  localparam logic [3:0] BLK_LANE2  = 4'd5;
  // Finalisation steps
  localparam logic [3:0] FIN_LEN    = 4'd0;
  localparam logic [3:0] FIN_ADD    = 4'd1;
  localparam logic [3:0] FIN_MUL1_A = 4'd2;
  localparam logic [3:0] FIN_MUL1_B = 4'd3;
  localparam logic [3:0] FIN_MUL2_A = 4'd4;
  localparam logic [3:0] FIN_MUL2_B = 4'd5;
  localparam logic [3:0] FIN_OUT_A  = 4'd6;
  localparam logic [3:0] FIN_OUT_B  = 4'd7;
  localparam logic [3:0] FIN_SUM    = 4'd8;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  state_e      state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        key_start_q, key_start_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] seed_q;
  cmd_t        cmd_q, cmd_d;
  logic [63:0] lane1_q, lane1_d;
  logic [63:0] lane2_q, lane2_d;
  logic [63:0] len_q, len_d;
  out_item_t   out_q, out_d;

  logic [63:0] mul_a, mul_b, prod;
  logic [63:0] mix1, mix2, prod_fold, lane1_fold, lane2_fold;
  logic        start;

  mmh3_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign mix1       = rotl64(lane1_q ^ prod, 27) + lane2_q;
  assign mix2       = rotl64(lane2_q ^ prod, 31) + lane1_q;
  assign prod_fold  = prod ^ (prod >> 33);
  assign lane1_fold = lane1_q ^ (lane1_q >> 33);
  assign lane2_fold = lane2_q ^ (lane2_q >> 33);

  // A new block may start when idle, or overlap the last step of a body block
  assign start = head_valid_i &&
                 ((state_q == ST_IDLE) ||
                  ((state_q == ST_BLOCK) && (step_q == BLK_LANE2) && !cmd_q.is_last));

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    key_start_d = key_start_q;
    out_valid_d = out_valid_q;
    cmd_d       = cmd_q;
    lane1_d     = lane1_q;
    lane2_d     = lane2_q;
    len_d       = len_q;
    out_d       = out_q;
    mul_a       = prod_fold;
    mul_b       = FMIX_F2;
    pop_o       = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        step_d = '0;
      end
      ST_BLOCK: begin
        step_d = step_q + 1'b1;
        case (step_q)
          BLK_HI: begin
            mul_a = cmd_q.word_hi;
            mul_b = MIX_C2;
          end
          BLK_ROT_LO: begin
            mul_a = rotl64(prod, 31);
            mul_b = MIX_C2;
          end
          BLK_ROT_HI: begin
            mul_a = rotl64(prod, 33);
            mul_b = MIX_C1;
          end
          BLK_LANE1: begin
            if (cmd_q.full_block) begin
              lane1_d = {mix1[61:0], 2'b00} + mix1 + MIX_N1;
            end else if (cmd_q.mix_lo) begin
              lane1_d = lane1_q ^ prod;
            end
          end
          BLK_LANE2: begin
            if (cmd_q.full_block) begin
              lane2_d = {mix2[61:0], 2'b00} + mix2 + MIX_N2;
            end else if (cmd_q.mix_hi) begin
              lane2_d = lane2_q ^ prod;
            end
            step_d  = FIN_LEN;
            state_d = cmd_q.is_last ? ST_FINAL : ST_IDLE;
          end
          default: begin
            step_d  = '0;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_FINAL: begin
        step_d = step_q + 1'b1;
        case (step_q)
          FIN_LEN: begin
            lane1_d = (lane1_q ^ len_q) + (lane2_q ^ len_q);
            lane2_d = lane2_q ^ len_q;
          end
          FIN_ADD: begin
            lane2_d = lane2_q + lane1_q;
          end
          FIN_MUL1_A: begin
            mul_a = lane1_fold;
            mul_b = FMIX_F1;
          end
          FIN_MUL1_B: begin
            mul_a = lane2_fold;
            mul_b = FMIX_F1;
          end
          FIN_MUL2_A, FIN_MUL2_B: begin
            mul_a = prod_fold;
            mul_b = FMIX_F2;
          end
          FIN_OUT_A: begin
            lane1_d = prod_fold;
          end
          FIN_OUT_B: begin
            lane2_d = prod_fold;
          end
          FIN_SUM: begin
            lane1_d = lane1_q + lane2_q;
            step_d  = '0;
            state_d = ST_EMIT;
          end
          default: begin
            step_d  = '0;
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.hash_first  = lane1_q;
          out_d.hash_second = lane2_q + lane1_q;
          out_valid_d       = 1'b1;
          key_start_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        step_d  = '0;
        state_d = ST_IDLE;
      end
    endcase

    if (start) begin
      pop_o       = 1'b1;
      cmd_d       = head_i;
      mul_a       = head_i.word_lo;
      mul_b       = MIX_C1;
      state_d     = ST_BLOCK;
      step_d      = BLK_HI;
      key_start_d = 1'b0;
      len_d       = (key_start_q ? 64'h0 : len_q) + 64'(head_i.byte_count);
      if (key_start_q) begin
        lane1_d = 64'(seed_q);
        lane2_d = 64'(seed_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      key_start_q <= 1'b1;
      out_valid_q <= 1'b0;
      seed_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      key_start_q <= key_start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    lane1_q <= lane1_d;
    lane2_q <= lane2_d;
    len_q   <= len_d;
    out_q   <= out_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;
  assign stat_o.busy      = (state_q != ST_IDLE);
  assign stat_o.key_start = key_start_q;

endmodule
